### rtl/csr_sparse_matrix_vector_mult_assert.svh
// assertion macros shared by the rtl
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULT_ASSERT_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked outside reset
`define SPMV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define SPMV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SPMV_ASSERT(lbl, prop, msg)
`define SPMV_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/csr_spmv_pkg.sv
package csr_spmv_pkg;

    localparam int IDX_W = 12;
    localparam int VAL_W = 32;
    localparam int SUM_W = 64;
    localparam int ROW_W = 20;
    localparam int LEN_W = 13;
    localparam int CMD_W = 2;

    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 88;
    localparam int OUT_TUSER_W = 3;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam int VEC_DEPTH_DEF = 4096;
    localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_NZ    = 2'd1,
        CMD_EMPTY = 2'd2
    } t_cmd;

    // register select is paddr[2]
    localparam logic REG_MODE = 1'b0;
    localparam logic REG_LEN  = 1'b1;

endpackage

### rtl/csr_sparse_matrix_vector_mult.sv
// CSR sparse matrix times dense vector. Load the vector first with cmd 0 words
// (index, Q16.16 value, NA mark in tuser), then stream the nonzeros in row order
// with cmd 1 (column index, Q16.16 value, tlast on the last nonzero of a row) or
// cmd 2 for an empty row. One result word comes out per row: the Q32.32 sum,
// saturated to 64 bits, with NA, saturation and bad index flags and the row
// number. The block takes one word per cycle, loads and nonzeros alike, unless a
// result waits on m_axis_tready and holds the pipeline. A nonzero passes the
// vector memory read, then the 32x32 multiply, then the saturating accumulate
// and the output register. The vector memory has a single port and
// serves one load write or one nonzero read per cycle; it needs no clearing,
// an element must be loaded before a nonzero reads it.
`include "csr_sparse_matrix_vector_mult_assert.svh"

module csr_sparse_matrix_vector_mult #(
    parameter int VEC_DEPTH = csr_spmv_pkg::VEC_DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // index[11:0], value[43:12], zero pad
    input  logic [csr_spmv_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                                   s_axis_tlast,
    // cmd[1:0], value_is_na[2]
    input  logic [csr_spmv_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // row_sum[63:0], row_number[83:64], zero pad
    output logic [csr_spmv_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // row_is_na[0], saturated[1], index_error[2]
    output logic [csr_spmv_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [csr_spmv_pkg::PADDR_W-1:0]       paddr,
    input  logic [csr_spmv_pkg::PDATA_W-1:0]       pwdata,
    output logic [csr_spmv_pkg::PDATA_W-1:0]       prdata,
    output logic                                   pready
);

    localparam int IDX_W = csr_spmv_pkg::IDX_W;
    localparam int VAL_W = csr_spmv_pkg::VAL_W;
    localparam int SUM_W = csr_spmv_pkg::SUM_W;
    localparam int ROW_W = csr_spmv_pkg::ROW_W;
    localparam int LEN_W = csr_spmv_pkg::LEN_W;
    localparam int AW    = $clog2(VEC_DEPTH);
    localparam int XW    = (AW + 1 > IDX_W + 1) ? AW + 1 : IDX_W + 1;
    localparam logic [XW-1:0] DEPTH_X = XW'(VEC_DEPTH);
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // config registers
    logic             r_mode;
    logic [LEN_W-1:0] r_len;

    // input word
    logic [csr_spmv_pkg::CMD_W-1:0] w_cmd;
    logic                           w_in_na;
    logic [IDX_W-1:0]               w_index;
    logic signed [VAL_W-1:0]        w_value;
    logic [XW-1:0]                  w_idx_x;
    logic                           w_in_store;
    logic [AW-1:0]                  w_addr;
    logic                           w_bad;
    logic                           w_accept;
    logic                           w_is_load;
    logic                           w_is_nz;
    logic                           w_is_empty;

    // vector memory: na mark in the top bit
    logic [VAL_W:0]                 r_vec_mem [VEC_DEPTH];
    logic [VAL_W:0]                 r_rd;

    // stage 1: memory read data
    logic                           r_v1;
    logic                           r_nz1;
    logic                           r_bad1;
    logic                           r_emit1;
    logic signed [VAL_W-1:0]        r_val1;
    logic signed [VAL_W-1:0]        w_elem;
    logic signed [SUM_W-1:0]        w_mult;
    logic signed [SUM_W-1:0]        w_logic;
    logic signed [SUM_W-1:0]        n_term2;
    logic                           w_add1;
    logic                           w_na1;

    // stage 2: product
    logic                           r_v2;
    logic signed [SUM_W-1:0]        r_term2;
    logic                           r_na2;
    logic                           r_bad2;
    logic                           r_emit2;

    // row accumulator
    logic signed [SUM_W-1:0]        r_acc;
    logic                           r_na_seen;
    logic                           r_ovf_seen;
    logic                           r_bad_seen;
    logic [ROW_W-1:0]               r_row;
    logic [SUM_W:0]                 w_sum_x;
    logic                           w_ovf;
    logic signed [SUM_W-1:0]        n_acc;
    logic                           n_na_seen;
    logic                           n_ovf_seen;
    logic                           n_bad_seen;

    // output register
    logic                           r_ov;
    logic signed [SUM_W-1:0]        r_o_sum;
    logic                           r_o_na;
    logic                           r_o_sat;
    logic                           r_o_bad;
    logic [ROW_W-1:0]               r_o_row;

    // flow control
    logic                           w_out_free;
    logic                           w_go2;
    logic                           w_ld2;
    logic                           w_ld1;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_len  <= csr_spmv_pkg::LEN_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                csr_spmv_pkg::REG_MODE: r_mode <= pwdata[0];
                csr_spmv_pkg::REG_LEN:  r_len  <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            csr_spmv_pkg::REG_MODE: prdata = {{(csr_spmv_pkg::PDATA_W-1){1'b0}}, r_mode};
            csr_spmv_pkg::REG_LEN:  prdata = {{(csr_spmv_pkg::PDATA_W-LEN_W){1'b0}}, r_len};
            default:                prdata = '0;
        endcase
    end

    // ---------------- input decode ----------------
    assign w_cmd      = s_axis_tuser[1:0];
    assign w_in_na    = s_axis_tuser[2];
    assign w_index    = s_axis_tdata[IDX_W-1:0];
    assign w_value    = s_axis_tdata[IDX_W +: VAL_W];
    assign w_idx_x    = XW'(w_index);
    assign w_in_store = w_idx_x < DEPTH_X;
    assign w_addr     = w_idx_x[AW-1:0];
    assign w_bad      = !w_in_store || ({1'b0, w_index} >= r_len);
    assign w_accept   = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_is_load  = 1'b0;
        w_is_nz    = 1'b0;
        w_is_empty = 1'b0;
        case (w_cmd)
            csr_spmv_pkg::CMD_LOAD:  w_is_load  = 1'b1;
            csr_spmv_pkg::CMD_NZ:    w_is_nz    = 1'b1;
            csr_spmv_pkg::CMD_EMPTY: w_is_empty = 1'b1;
            default: ;
        endcase
    end

    // ---------------- flow control ----------------
    assign w_out_free    = !r_ov || m_axis_tready;
    assign w_go2         = r_v2 && (!r_emit2 || w_out_free);
    assign w_ld2         = !r_v2 || w_go2;
    assign w_ld1         = !r_v1 || w_ld2;
    assign s_axis_tready = w_ld1;

    // ---------------- vector memory ----------------
    always_ff @(posedge i_clk) begin
        if (w_accept && w_is_load && w_in_store) begin
            r_vec_mem[w_addr] <= {w_in_na, w_value};
        end
        if (w_ld1) begin
            r_rd <= r_vec_mem[w_addr];
        end
    end

    // ---------------- stage 1 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_ld1) begin
            r_v1 <= w_accept && (w_is_nz || w_is_empty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld1) begin
            r_nz1   <= w_is_nz;
            r_bad1  <= w_is_nz && w_bad;
            r_emit1 <= w_is_empty || (w_is_nz && s_axis_tlast);
            r_val1  <= w_value;
        end
    end

    assign w_elem  = r_rd[VAL_W-1:0];
    assign w_na1   = r_nz1 && !r_bad1 && r_rd[VAL_W];
    assign w_add1  = r_nz1 && !r_bad1 && !r_rd[VAL_W];
    assign w_mult  = SUM_W'(r_val1) * SUM_W'(w_elem);
    // logical mode: a nonzero element counts as 1.0
    assign w_logic = (w_elem != '0) ? {{(SUM_W-VAL_W-16){r_val1[VAL_W-1]}}, r_val1, 16'h0000}
                                    : '0;
    assign n_term2 = w_add1 ? (r_mode ? w_logic : w_mult) : '0;

    // ---------------- stage 2 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_ld2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld2) begin
            r_term2 <= n_term2;
            r_na2   <= w_na1;
            r_bad2  <= r_bad1;
            r_emit2 <= r_emit1;
        end
    end

    // saturating accumulate
    assign w_sum_x = {r_acc[SUM_W-1], r_acc} + {r_term2[SUM_W-1], r_term2};
    assign w_ovf   = w_sum_x[SUM_W] != w_sum_x[SUM_W-1];

    always_comb begin
        if (w_ovf) begin
            n_acc = w_sum_x[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            n_acc = w_sum_x[SUM_W-1:0];
        end
        n_na_seen  = r_na_seen || r_na2;
        n_ovf_seen = r_ovf_seen || w_ovf;
        n_bad_seen = r_bad_seen || r_bad2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_na_seen  <= 1'b0;
            r_ovf_seen <= 1'b0;
            r_bad_seen <= 1'b0;
            r_row      <= '0;
        end else if (w_go2) begin
            if (r_emit2) begin
                r_acc      <= '0;
                r_na_seen  <= 1'b0;
                r_ovf_seen <= 1'b0;
                r_bad_seen <= 1'b0;
                r_row      <= r_row + ROW_W'(1);
            end else begin
                r_acc      <= n_acc;
                r_na_seen  <= n_na_seen;
                r_ovf_seen <= n_ovf_seen;
                r_bad_seen <= n_bad_seen;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_go2 && r_emit2) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go2 && r_emit2) begin
            r_o_sum <= n_na_seen ? '0 : n_acc;
            r_o_na  <= n_na_seen;
            r_o_sat <= n_ovf_seen;
            r_o_bad <= n_bad_seen;
            r_o_row <= r_row;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {{(csr_spmv_pkg::OUT_TDATA_W-SUM_W-ROW_W){1'b0}}, r_o_row, r_o_sum};
    assign m_axis_tuser  = {r_o_bad, r_o_sat, r_o_na};

    // ---------------- assertions ----------------
    `SPMV_ASSERT(a_row_clear, (w_go2 && r_emit2) |=> (r_acc == '0) && !r_na_seen && !r_ovf_seen && !r_bad_seen, "row state not cleared after result")
    `SPMV_ASSERT(a_row_count, (w_go2 && r_emit2) |=> (r_row == $past(r_row) + ROW_W'(1)), "row number did not advance")
    `SPMV_ASSERT(a_na_zero, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[SUM_W-1:0] == '0), "NA row carries a nonzero sum")
    `SPMV_ASSERT(a_stall_full, !s_axis_tready |-> (r_v1 && r_v2), "input stalled with a free stage")
    `SPMV_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (!m_axis_tvalid && !r_v1 && !r_v2), "pipeline not empty after reset")

endmodule
